/* rtl/core/gbpw_pkg.sv */
// gbpw_pkg: shared types and constants for the glyph bitmap pixel writer
`default_nettype none

package gbpw_pkg;

   // glyph geometry
   localparam int COORD_WIDTH = 12;
   localparam int MAX_PITCH   = 256;
   localparam int PITCH_WIDTH = $clog2(MAX_PITCH + 1);
   localparam int NEED_WIDTH  = COORD_WIDTH - 2;
   localparam int NEED_MAX    = 1 << (COORD_WIDTH - 3);
   localparam int SPAN_MAX    = (MAX_PITCH > NEED_MAX) ? MAX_PITCH : NEED_MAX;
   localparam int BYTE_WIDTH  = $clog2(SPAN_MAX);
   localparam int SPAN_WIDTH  = BYTE_WIDTH + 1;

   // framebuffer side
   localparam int ADDR_WIDTH  = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int LINE_WIDTH  = 16;
   localparam int BPP_WIDTH   = 6;
   localparam int SIZE_WIDTH  = 2;
   localparam int SHIFT_WIDTH = 2;

   // operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // write size codes
   localparam logic [SIZE_WIDTH-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_WIDTH-1:0] SIZE_HALF = 2'd1;
   localparam logic [SIZE_WIDTH-1:0] SIZE_WORD = 2'd2;

   // supported pixel depths
   localparam logic [BPP_WIDTH-1:0] BPP_8     = 6'd8;
   localparam logic [BPP_WIDTH-1:0] BPP_16    = 6'd16;
   localparam logic [BPP_WIDTH-1:0] BPP_32    = 6'd32;
   localparam logic [BPP_WIDTH-1:0] BPP_RESET = BPP_16;

   // register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_BASE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_BYTES  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BPP         = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FOREGROUND  = 2'd3;

   typedef struct packed {
      logic                   operation;
      logic [COORD_WIDTH-1:0] left_column;
      logic [COORD_WIDTH-1:0] top_row;
      logic [COORD_WIDTH-1:0] right_column;
      logic [COORD_WIDTH-1:0] bottom_row;
      logic [PITCH_WIDTH-1:0] row_pitch;
      logic [7:0]             bitmap_byte;
   } req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] write_address;
      logic [DATA_WIDTH-1:0] write_data;
      logic [SIZE_WIDTH-1:0] write_size;
      logic                  last_write;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/glyph_bitmap_pixel_writer.sv */
// glyph_bitmap_pixel_writer: turns glyph bitmap bytes into framebuffer pixel writes
//
// Usage: a start item on req_ loads the glyph box and row pitch; bitmap byte items
// follow in buffer order. Each set bit that falls inside the box gives one write
// item on rsp_ (address, data, size), leftmost pixel first, with last_write on the
// final write of that byte. Bytes that produce no writes give no rsp_ item.
// Registers are written through csr_ (index, data); csr_ready is always high.
// A byte's writes pass through the pixel stage and then the output register to rsp_.
// The single pixel stage gives one write item per cycle while rsp_stall is low.
// The pixel stage takes the next byte in the cycle its last write moves to the output
// register, so while rsp_stall is low, bytes with one write each stream at one per
// cycle. rsp_stall holds the output register and, once the pixel stage fills behind
// it, raises req_stall.
// Reset (synchronous, active high) empties both stages, clears the glyph box and
// restores the register reset values (bits_per_pixel 16, the rest zero).
`default_nettype none

module glyph_bitmap_pixel_writer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request items
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire gbpw_pkg::req_type                     req_payload,
   // write items
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      gbpw_pkg::rsp_type                     rsp_payload,
   // register writes
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [gbpw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [31:0]                           csr_data
);

   localparam int CW = gbpw_pkg::COORD_WIDTH;
   localparam int BW = gbpw_pkg::BYTE_WIDTH;
   localparam int SW = gbpw_pkg::SPAN_WIDTH;
   localparam int PW = gbpw_pkg::PITCH_WIDTH;
   localparam int NW = gbpw_pkg::NEED_WIDTH;
   localparam int AW = gbpw_pkg::ADDR_WIDTH;
   localparam int DW = gbpw_pkg::DATA_WIDTH;

   // configuration registers
   logic [AW-1:0]                      frame_base_ff;
   logic [gbpw_pkg::LINE_WIDTH-1:0]    line_bytes_ff;
   logic [gbpw_pkg::BPP_WIDTH-1:0]     bpp_ff;
   logic [DW-1:0]                      foreground_ff;

   // glyph box and position
   logic [CW-1:0] box_left_ff, box_left_in;
   logic [CW-1:0] box_top_ff, box_top_in;
   logic [CW-1:0] box_right_ff, box_right_in;
   logic [CW-1:0] box_bottom_ff, box_bottom_in;
   logic [PW-1:0] box_pitch_ff, box_pitch_in;
   logic [CW-1:0] current_row_ff, current_row_in;
   logic [BW-1:0] byte_in_row_ff, byte_in_row_in;

   // pixel stage
   logic [7:0]                          mask_ff, mask_in;
   logic [AW-1:0]                       row_addr_ff, row_addr_in;
   logic [CW-1:0]                       base_x_ff, base_x_in;
   logic [gbpw_pkg::SHIFT_WIDTH-1:0]    shift_ff, shift_in;
   logic [gbpw_pkg::SIZE_WIDTH-1:0]     size_ff, size_in;
   logic [DW-1:0]                       data_ff, data_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   gbpw_pkg::rsp_type rsp_ff, rsp_in;

   // front-end decode
   logic                                 accept;
   logic                                 row_active;
   logic                                 depth_ok;
   logic [NW-1:0]                        need;
   logic [CW:0]                          width_ext;
   logic [SW-1:0]                        span;
   logic [SW-1:0]                        byte_next;
   logic [CW-1:0]                        base_x;
   logic [7:0]                           pix_mask;
   logic [CW+gbpw_pkg::LINE_WIDTH-1:0]   row_offset;
   logic [AW-1:0]                        row_addr;
   logic [gbpw_pkg::SHIFT_WIDTH-1:0]     pix_shift;
   logic [gbpw_pkg::SIZE_WIDTH-1:0]      pix_size;
   logic [DW-1:0]                        pix_data;

   // back-end select
   logic          advance;
   logic          one_left;
   logic          stage_free;
   logic [2:0]    pick;
   logic [7:0]    mask_rest;
   logic [CW-1:0] pix_x;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // pixel stage hand-off
   assign advance    = (|mask_ff) && (!rsp_valid_ff || !rsp_stall);
   assign one_left   = ((mask_ff & (mask_ff - 8'd1)) == 8'd0);
   assign stage_free = !(|mask_ff) || (advance && one_left);
   assign req_stall  = !stage_free;
   assign accept     = req_valid && stage_free;

   // pixel format from the configured depth
   always_comb begin
      depth_ok  = 1'b1;
      pix_shift = 2'd0;
      pix_size  = gbpw_pkg::SIZE_BYTE;
      pix_data  = '0;
      unique case (bpp_ff)
         gbpw_pkg::BPP_8: begin
            pix_data = {24'd0, foreground_ff[7:0]};
         end
         gbpw_pkg::BPP_16: begin
            pix_shift = 2'd1;
            pix_size  = gbpw_pkg::SIZE_HALF;
            pix_data  = {16'd0, foreground_ff[23:19], foreground_ff[15:10],
                         foreground_ff[7:3]};
         end
         gbpw_pkg::BPP_32: begin
            pix_shift = 2'd2;
            pix_size  = gbpw_pkg::SIZE_WORD;
            pix_data  = foreground_ff;
         end
         default: begin
            depth_ok = 1'b0;
         end
      endcase
   end

   // bytes needed per row and the row span
   always_comb begin
      width_ext = {1'b0, box_right_ff} - {1'b0, box_left_ff} + (CW+1)'(7);
      need      = (box_right_ff > box_left_ff) ? NW'(width_ext >> 3) : '0;
      span      = SW'(box_pitch_ff);
      if (SW'(need) > span) begin
         span = SW'(need);
      end
      if (span == '0) begin
         span = SW'(1);
      end
      byte_next = SW'(byte_in_row_ff) + SW'(1);
   end

   // pixel mask for the incoming byte, leftmost pixel in bit 0
   always_comb begin
      row_active = (current_row_ff < box_bottom_ff);
      base_x     = box_left_ff + CW'({byte_in_row_ff, 3'b000});
      row_offset = current_row_ff * line_bytes_ff;
      row_addr   = frame_base_ff + AW'(row_offset);
      for (int j = 0; j < 8; j++) begin
         pix_mask[j] = req_payload.bitmap_byte[7-j] &&
                       (({1'b0, base_x} + (CW+1)'(j)) < {1'b0, box_right_ff});
      end
      if (!(depth_ok && row_active && (SW'(byte_in_row_ff) < SW'(need)))) begin
         pix_mask = '0;
      end
   end

   // first remaining pixel of the stage
   always_comb begin
      pick = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (mask_ff[j]) begin
            pick = 3'(j);
         end
      end
      mask_rest = mask_ff & ~(8'd1 << pick);
      pix_x     = base_x_ff + CW'(pick);
   end

   // next state
   always_comb begin
      box_left_in    = box_left_ff;
      box_top_in     = box_top_ff;
      box_right_in   = box_right_ff;
      box_bottom_in  = box_bottom_ff;
      box_pitch_in   = box_pitch_ff;
      current_row_in = current_row_ff;
      byte_in_row_in = byte_in_row_ff;
      mask_in        = mask_ff;
      row_addr_in    = row_addr_ff;
      base_x_in      = base_x_ff;
      shift_in       = shift_ff;
      size_in        = size_ff;
      data_in        = data_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      // output register
      if (advance) begin
         rsp_valid_in          = 1'b1;
         rsp_in.write_address  = row_addr_ff + (AW'(pix_x) << shift_ff);
         rsp_in.write_data     = data_ff;
         rsp_in.write_size     = size_ff;
         rsp_in.last_write     = (mask_rest == 8'd0);
         mask_in               = mask_rest;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // accepted item
      if (accept) begin
         unique case (req_payload.operation)
            gbpw_pkg::OP_START: begin
               box_left_in    = req_payload.left_column;
               box_top_in     = req_payload.top_row;
               box_right_in   = req_payload.right_column;
               box_bottom_in  = req_payload.bottom_row;
               box_pitch_in   = (req_payload.row_pitch > PW'(gbpw_pkg::MAX_PITCH)) ?
                                PW'(gbpw_pkg::MAX_PITCH) : req_payload.row_pitch;
               current_row_in = req_payload.top_row;
               byte_in_row_in = '0;
            end
            default: begin
               if (row_active) begin
                  if (byte_next >= span) begin
                     byte_in_row_in = '0;
                     current_row_in = current_row_ff + CW'(1);
                  end else begin
                     byte_in_row_in = BW'(byte_next);
                  end
               end
               if (pix_mask != 8'd0) begin
                  mask_in     = pix_mask;
                  row_addr_in = row_addr;
                  base_x_in   = base_x;
                  shift_in    = pix_shift;
                  size_in     = pix_size;
                  data_in     = pix_data;
               end
            end
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
         line_bytes_ff <= '0;
         bpp_ff        <= gbpw_pkg::BPP_RESET;
         foreground_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gbpw_pkg::CSR_FRAME_BASE: frame_base_ff <= csr_data;
            gbpw_pkg::CSR_LINE_BYTES: line_bytes_ff <= csr_data[gbpw_pkg::LINE_WIDTH-1:0];
            gbpw_pkg::CSR_BPP:        bpp_ff        <= csr_data[gbpw_pkg::BPP_WIDTH-1:0];
            gbpw_pkg::CSR_FOREGROUND: foreground_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff    <= '0;
         box_top_ff     <= '0;
         box_right_ff   <= '0;
         box_bottom_ff  <= '0;
         box_pitch_ff   <= '0;
         current_row_ff <= '0;
         byte_in_row_ff <= '0;
         mask_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         box_left_ff    <= box_left_in;
         box_top_ff     <= box_top_in;
         box_right_ff   <= box_right_in;
         box_bottom_ff  <= box_bottom_in;
         box_pitch_ff   <= box_pitch_in;
         current_row_ff <= current_row_in;
         byte_in_row_ff <= byte_in_row_in;
         mask_ff        <= mask_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      row_addr_ff <= row_addr_in;
      base_x_ff   <= base_x_in;
      shift_ff    <= shift_in;
      size_ff     <= size_in;
      data_ff     <= data_in;
      rsp_ff      <= rsp_in;
   end

endmodule

`default_nettype wire
